// ----- design/otwk_pkg.sv -----
// ============================================================================
// otwk_pkg
// Shared widths, constants and the arctangent table for the three-wheel
// omni drive kinematics pipeline.
// ============================================================================
package otwk_pkg;

  // Default port widths
  localparam int unsigned VEL_WIDTH_DEF   = 16;
  localparam int unsigned ANGLE_WIDTH_DEF = 16;

  // Internal velocity scale is about Q1.31
  localparam int unsigned INT_W        = 32;
  localparam int unsigned CORDIC_STEPS = 24;

  // CORDIC datapath widths: vector grows by the CORDIC gain and sqrt(2)
  localparam int unsigned XY_W = 35;
  localparam int unsigned Z_W  = 34;

  // Gain compensation split into two partial products
  localparam int unsigned GL_W  = 17;                 // low slice, unsigned
  localparam int unsigned GH_W  = XY_W - GL_W;        // high slice, signed
  localparam int unsigned GC_W  = 30;                 // constant width
  localparam int unsigned PL_W  = GL_W + GC_W;        // low product
  localparam int unsigned PH_W  = GH_W + GC_W + 1;    // high product
  localparam int unsigned GS_W  = PH_W + GL_W + 1;    // recombined sum
  localparam int unsigned GSHIFT = 30;

  // Robot-frame velocity and projection product widths
  localparam int unsigned LX_W = 34;
  localparam int unsigned P_W  = 53;

  localparam logic [GC_W-1:0] INV_GAIN   = 30'd652032874;  // 1/K in Q30
  localparam logic [16:0]     SQRT3_HALF = 17'd56756;      // sqrt(3)/2 in Q16

  // arctan(2^-i) with one turn = 2^32
  function automatic logic [INT_W-1:0] atan_turn(input int unsigned idx);
    logic [INT_W-1:0] a;
    unique case (idx)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2FA;
      15: a = 32'h0000517D;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A30;
      19: a = 32'h00000518;
      20: a = 32'h0000028C;
      21: a = 32'h00000146;
      22: a = 32'h000000A3;
      23: a = 32'h00000051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ----- design/omni_three_wheel_kinematics_top.sv -----
// ============================================================================
// omni_three_wheel_kinematics_top
// Inverse kinematics for a three-wheel omni base: optional world-to-robot
// rotation by a pipelined CORDIC, gain compensation, then wheel projection.
// ============================================================================
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  in      | input     | in_valid / in_ready  | in_mode, in_vel_x, in_vel_y,
//          |           |                      | in_heading
//  out     | output    | out_valid/out_ready  | out_wheel_one/two/three
//
//  One transaction enters per cycle while the output is not held; the pipeline
//  is the entry stage, one CORDIC iteration per stage,
//  two gain stages and two projection stages.
//  Reset (synchronous, active low) clears the valid bits of every stage.
//  A stall at the output freezes the whole pipeline; no stage moves while
//  the output holds, so nothing is lost or repeated.
//  Robot-frame transactions pass through the CORDIC stages unrotated.
// ============================================================================
module omni_three_wheel_kinematics_top #(
  parameter int unsigned VEL_WIDTH   = otwk_pkg::VEL_WIDTH_DEF,
  parameter int unsigned ANGLE_WIDTH = otwk_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_mode,
  input  logic signed [VEL_WIDTH-1:0] in_vel_x,
  input  logic signed [VEL_WIDTH-1:0] in_vel_y,
  input  logic [ANGLE_WIDTH-1:0]      in_heading,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [VEL_WIDTH:0]   out_wheel_one,
  output logic signed [VEL_WIDTH:0]   out_wheel_two,
  output logic signed [VEL_WIDTH:0]   out_wheel_three
);

  localparam int unsigned NS     = otwk_pkg::CORDIC_STEPS;
  localparam int unsigned XY_W   = otwk_pkg::XY_W;
  localparam int unsigned Z_W    = otwk_pkg::Z_W;
  localparam int unsigned INT_W  = otwk_pkg::INT_W;
  localparam int unsigned GL_W   = otwk_pkg::GL_W;
  localparam int unsigned GH_W   = otwk_pkg::GH_W;
  localparam int unsigned PL_W   = otwk_pkg::PL_W;
  localparam int unsigned PH_W   = otwk_pkg::PH_W;
  localparam int unsigned GS_W   = otwk_pkg::GS_W;
  localparam int unsigned LX_W   = otwk_pkg::LX_W;
  localparam int unsigned P_W    = otwk_pkg::P_W;
  localparam int unsigned VSCALE = INT_W - VEL_WIDTH;
  localparam int unsigned ASCALE = INT_W - ANGLE_WIDTH;
  localparam int unsigned OSH    = 16 + VSCALE;

  localparam logic signed [GS_W-1:0] G_RND = GS_W'(1) <<< (otwk_pkg::GSHIFT - 1);
  localparam logic signed [P_W-1:0]  O_RND = P_W'(1) <<< (OSH - 1);

  // Global advance: the pipeline moves unless the output is held
  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // --------------------------------------------------------------------------
  // Stage 0: scale to internal format, fold heading into +/- quarter turn
  // --------------------------------------------------------------------------
  logic signed [XY_W-1:0] vx_s, vy_s;
  logic [INT_W-1:0]       phi, phi_f;
  logic                   flip;
  logic signed [XY_W-1:0] x0_nxt, y0_nxt;
  logic signed [Z_W-1:0]  z0_nxt;

  always_comb begin
    vx_s   = XY_W'(in_vel_x) <<< VSCALE;
    vy_s   = XY_W'(in_vel_y) <<< VSCALE;
    phi    = INT_W'(0) - (INT_W'(in_heading) << ASCALE);
    flip   = in_mode && ((phi[INT_W-1:INT_W-2] == 2'b01) ||
                         (phi[INT_W-1:INT_W-2] == 2'b10));
    phi_f  = flip ? {~phi[INT_W-1], phi[INT_W-2:0]} : phi;
    z0_nxt = Z_W'($signed(phi_f));
    x0_nxt = flip ? -vx_s : vx_s;
    y0_nxt = flip ? -vy_s : vy_s;
  end

  // CORDIC stage registers, index 0 is the entry stage
  logic signed [XY_W-1:0] x_r  [0:NS];
  logic signed [XY_W-1:0] y_r  [0:NS];
  logic signed [Z_W-1:0]  z_r  [0:NS];
  logic                   md_r [0:NS];
  logic                   vld_r[0:NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0]  <= x0_nxt;
      y_r[0]  <= y0_nxt;
      z_r[0]  <= z0_nxt;
      md_r[0] <= in_mode;
    end
  end

  // --------------------------------------------------------------------------
  // CORDIC: one rotation step per stage; robot-frame items pass unchanged
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < NS; i++) begin : g_cordic
    logic signed [XY_W-1:0] dx, dy;
    logic signed [Z_W-1:0]  da;
    logic signed [XY_W-1:0] x_nxt, y_nxt;
    logic signed [Z_W-1:0]  z_nxt;

    always_comb begin
      dx = y_r[i] >>> i;
      dy = x_r[i] >>> i;
      da = Z_W'(otwk_pkg::atan_turn(i));
      if (!md_r[i]) begin
        x_nxt = x_r[i];
        y_nxt = y_r[i];
        z_nxt = z_r[i];
      end else if (!z_r[i][Z_W-1]) begin
        x_nxt = x_r[i] - dx;
        y_nxt = y_r[i] + dy;
        z_nxt = z_r[i] - da;
      end else begin
        x_nxt = x_r[i] + dx;
        y_nxt = y_r[i] - dy;
        z_nxt = z_r[i] + da;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (adv) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[i+1]  <= x_nxt;
        y_r[i+1]  <= y_nxt;
        z_r[i+1]  <= z_nxt;
        md_r[i+1] <= md_r[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Gain stage 1: partial products of x, y by 1/K
  // --------------------------------------------------------------------------
  logic [PL_W-1:0]        pxl_r, pyl_r;
  logic signed [PH_W-1:0] pxh_r, pyh_r;
  logic signed [LX_W-1:0] xb_r, yb_r;
  logic                   g1_md_r, g1_vld_r;

  logic signed [GH_W:0]   cxh, cyh;
  logic signed [otwk_pkg::GC_W:0] gc_s;

  always_comb begin
    cxh  = (GH_W+1)'($signed(x_r[NS][XY_W-1:GL_W]));
    cyh  = (GH_W+1)'($signed(y_r[NS][XY_W-1:GL_W]));
    gc_s = $signed({1'b0, otwk_pkg::INV_GAIN});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_vld_r <= 1'b0;
    end else if (adv) begin
      g1_vld_r <= vld_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pxl_r   <= PL_W'(x_r[NS][GL_W-1:0]) * PL_W'(otwk_pkg::INV_GAIN);
      pyl_r   <= PL_W'(y_r[NS][GL_W-1:0]) * PL_W'(otwk_pkg::INV_GAIN);
      pxh_r   <= PH_W'(cxh) * PH_W'(gc_s);
      pyh_r   <= PH_W'(cyh) * PH_W'(gc_s);
      xb_r    <= x_r[NS][LX_W-1:0];
      yb_r    <= y_r[NS][LX_W-1:0];
      g1_md_r <= md_r[NS];
    end
  end

  // --------------------------------------------------------------------------
  // Gain stage 2: recombine, round half up, select frame
  // --------------------------------------------------------------------------
  logic signed [GS_W-1:0] gsx, gsy;
  logic signed [LX_W-1:0] lx_nxt, ly_nxt;
  logic signed [LX_W-1:0] lx_r, ly_r;
  logic                   g2_vld_r;

  always_comb begin
    gsx = (GS_W'(pxh_r) <<< GL_W) + $signed(GS_W'(pxl_r)) + G_RND;
    gsy = (GS_W'(pyh_r) <<< GL_W) + $signed(GS_W'(pyl_r)) + G_RND;
    lx_nxt = g1_md_r ? LX_W'(gsx >>> otwk_pkg::GSHIFT) : xb_r;
    ly_nxt = g1_md_r ? LX_W'(gsy >>> otwk_pkg::GSHIFT) : yb_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g2_vld_r <= 1'b0;
    end else if (adv) begin
      g2_vld_r <= g1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lx_r <= lx_nxt;
      ly_r <= ly_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Projection stage 1: 0.5*lx as a shift, (sqrt3/2)*ly as a product
  // --------------------------------------------------------------------------
  logic signed [P_W-1:0] pa_r, pb_r;
  logic                  p1_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (adv) begin
      p1_vld_r <= g2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r <= P_W'(lx_r) <<< 15;
      pb_r <= P_W'(ly_r) * P_W'($signed({1'b0, otwk_pkg::SQRT3_HALF}));
    end
  end

  // --------------------------------------------------------------------------
  // Projection stage 2: wheel sums, round half up, output register
  // --------------------------------------------------------------------------
  logic signed [P_W-1:0]       s1, s2, s3;
  logic signed [VEL_WIDTH:0]   w1_nxt, w2_nxt, w3_nxt;
  logic signed [VEL_WIDTH:0]   w1_r, w2_r, w3_r;

  always_comb begin
    s1     = pa_r + pb_r + O_RND;
    s2     = pa_r - pb_r + O_RND;
    s3     = O_RND - (pa_r <<< 1);
    w1_nxt = (VEL_WIDTH+1)'(s1 >>> OSH);
    w2_nxt = (VEL_WIDTH+1)'(s2 >>> OSH);
    w3_nxt = (VEL_WIDTH+1)'(s3 >>> OSH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w1_r <= w1_nxt;
      w2_r <= w2_nxt;
      w3_r <= w3_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_wheel_one   = w1_r;
  assign out_wheel_two   = w2_r;
  assign out_wheel_three = w3_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // A held output freezes the valid bits of the last CORDIC, gain and projection stages
  a_stall_freeze : assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(g1_vld_r) && $stable(g2_vld_r) && $stable(p1_vld_r)
              && $stable(vld_r[NS])))
    else $error("pipeline valid bits moved during a stall");

  // A rotated item leaves the CORDIC with its angle driven near zero
  a_cordic_conv : assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NS] && md_r[NS]) |->
      (($signed(z_r[NS]) <= $signed(Z_W'(512))) &&
       ($signed(z_r[NS]) >= -$signed(Z_W'(512)))))
    else $error("CORDIC residual angle out of bound");

  // Robot-frame items are not rotated by the first CORDIC step
  a_bypass : assert property (@(posedge clk) disable iff (!rst_n)
    (adv && vld_r[0] && !md_r[0]) |=>
      ((x_r[1] == $past(x_r[0])) && (y_r[1] == $past(y_r[0]))))
    else $error("robot-frame transaction was rotated");

  // A result appears only when the projection stage held an item
  a_out_source : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(p1_vld_r))
    else $error("result without a source transaction");

endmodule

// ----- bench/tb_omni_three_wheel_kinematics_top.sv -----
// ============================================================================
// tb_omni_three_wheel_kinematics_top
// Self-checking bench for the three-wheel omni kinematics pipeline. A table
// of directed commands covers velocity extremes, both frame modes and the
// quadrant edges of the heading. A random phase follows. Each accepted
// command is scored against its table values or a bit-true CORDIC and
// wheel-projection predictor. Both handshakes idle at random.
// ============================================================================
module tb_omni_three_wheel_kinematics_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW = otwk_pkg::VEL_WIDTH_DEF;
  localparam int AW = otwk_pkg::ANGLE_WIDTH_DEF;
  localparam int ROTATE_STEPS = 24;
  localparam int RANDOM_CMDS = 450;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 200000;
  localparam longint INV_GAIN_Q30 = 64'sd652032874;
  localparam longint SIN60_Q16 = 64'sd56756;
  localparam longint HALF_Q16 = 64'sd32768;
  localparam longint ROUND_Q30 = 64'sd1 <<< 29;
  localparam longint ROUND_OUT = 64'sd1 <<< 31;
  localparam logic FRAME_ROBOT = 1'b0;
  localparam logic FRAME_WORLD = 1'b1;

  // arctan(2^-k), one turn = 2^32
  localparam longint ARCTAN_STEP [ROTATE_STEPS] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  typedef struct packed {
    logic signed [VW:0] one;
    logic signed [VW:0] two;
    logic signed [VW:0] three;
  } wheel_speeds_t;

  typedef struct packed {
    logic                 mode;
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
    logic [AW-1:0]        hd;
    bit                   typed;
    wheel_speeds_t        speeds;
  } cmd_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_mode = 1'b0;
  logic signed [VW-1:0] in_vel_x = '0;
  logic signed [VW-1:0] in_vel_y = '0;
  logic [AW-1:0]        in_heading = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [VW:0]   out_wheel_one;
  logic signed [VW:0]   out_wheel_two;
  logic signed [VW:0]   out_wheel_three;

  wheel_speeds_t pending_speeds[$];
  cmd_row_t      directed_rows[$];
  int            cycle_count = 0;
  int            error_count = 0;
  int            speeds_checked = 0;
  int            world_cmds = 0;
  int            robot_cmds = 0;
  bit            no_idle = 1'b0;

  omni_three_wheel_kinematics_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_vel_x       (in_vel_x),
    .in_vel_y       (in_vel_y),
    .in_heading     (in_heading),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_wheel_one  (out_wheel_one),
    .out_wheel_two  (out_wheel_two),
    .out_wheel_three(out_wheel_three)
  );

  // Clock and cycle count
  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d speeds still pending", cycle_count,
             pending_speeds.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // Wheel speeds for one command: optional rotation by -heading, then projection
  function automatic wheel_speeds_t predict_speeds(input logic mode,
                                                   input logic signed [VW-1:0] vx,
                                                   input logic signed [VW-1:0] vy,
                                                   input logic [AW-1:0] hd);
    longint        rx, ry, cx, cy, dx, dy, ang, s1, s2, s3;
    logic [31:0]   phi;
    int            k;
    wheel_speeds_t r;
    rx = longint'(vx) <<< (32 - VW);
    ry = longint'(vy) <<< (32 - VW);
    if (mode == FRAME_WORLD) begin
      phi = 32'd0 - ({hd, {(32 - AW){1'b0}}});
      cx = rx;
      cy = ry;
      // angles past a quarter turn: flip the vector, move half a turn
      if (phi[31:30] == 2'd1 || phi[31:30] == 2'd2) begin
        cx = -cx;
        cy = -cy;
        phi = phi - 32'h8000_0000;
      end
      ang = longint'($signed(phi));
      for (k = 0; k < ROTATE_STEPS; k++) begin
        dx = cy >>> k;
        dy = cx >>> k;
        if (ang >= 0) begin
          cx -= dx;
          cy += dy;
          ang -= ARCTAN_STEP[k];
        end else begin
          cx += dx;
          cy -= dy;
          ang += ARCTAN_STEP[k];
        end
      end
      rx = (cx * INV_GAIN_Q30 + ROUND_Q30) >>> 30;
      ry = (cy * INV_GAIN_Q30 + ROUND_Q30) >>> 30;
    end
    s1 = (rx * HALF_Q16 + ry * SIN60_Q16 + ROUND_OUT) >>> (48 - VW);
    s2 = (rx * HALF_Q16 - ry * SIN60_Q16 + ROUND_OUT) >>> (48 - VW);
    s3 = (-rx * 64'sd65536 + ROUND_OUT) >>> (48 - VW);
    r.one = s1[VW:0];
    r.two = s2[VW:0];
    r.three = s3[VW:0];
    return r;
  endfunction

  function automatic cmd_row_t cmd_row(input logic mode, input int vx, input int vy,
                                       input int hd, input bit typed = 1'b0,
                                       input int e1 = 0, input int e2 = 0,
                                       input int e3 = 0);
    cmd_row_t r;
    r.mode = mode;
    r.vx = VW'(vx);
    r.vy = VW'(vy);
    r.hd = AW'(hd);
    r.typed = typed;
    r.speeds.one = (VW + 1)'(e1);
    r.speeds.two = (VW + 1)'(e2);
    r.speeds.three = (VW + 1)'(e3);
    return r;
  endfunction

  function automatic logic signed [VW-1:0] pick_velocity();
    logic signed [VW-1:0] v;
    case ($urandom_range(0, 15))
      0: v = {1'b1, {(VW - 1){1'b0}}};
      1: v = {1'b0, {(VW - 1){1'b1}}};
      2: v = '0;
      3: v = '1;
      default: v = VW'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [AW-1:0] pick_heading();
    logic [AW-1:0] h;
    if ($urandom_range(0, 5) == 0) begin
      // quadrant edges
      case ($urandom_range(0, 8))
        0: h = 16'h0000;
        1: h = 16'h3FFF;
        2: h = 16'h4000;
        3: h = 16'h4001;
        4: h = 16'h7FFF;
        5: h = 16'h8000;
        6: h = 16'hBFFF;
        7: h = 16'hC000;
        default: h = 16'hFFFF;
      endcase
    end else begin
      h = AW'($urandom);
    end
    return h;
  endfunction

  task automatic note_mismatch(input string what, input int want, input int got);
    error_count++;
    if (error_count <= 10)
      $display("[%0t] mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  task automatic check_field(input string what, input logic signed [VW:0] want,
                             input logic signed [VW:0] got);
    if (got !== want) note_mismatch(what, want, got);
  endtask

  // Drive one command transaction; the expectation is queued on acceptance
  task automatic send_command(input cmd_row_t c);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= c.mode;
    in_vel_x <= c.vx;
    in_vel_y <= c.vy;
    in_heading <= c.hd;
    do @(posedge clk); while (!in_ready);
    pending_speeds.push_back(c.typed ? c.speeds : predict_speeds(c.mode, c.vx, c.vy, c.hd));
    if (c.mode == FRAME_WORLD) world_cmds++;
    else robot_cmds++;
  endtask

  // Hold off the sender until every pending result has drained
  task automatic drain_pending();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_speeds.size() != 0);
  endtask

  // Result side: random back-pressure
  initial begin : result_sink
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Scoreboard
  always @(posedge clk) begin : score_speeds
    wheel_speeds_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_speeds.size() == 0) begin
        note_mismatch("unexpected result, pending count", 0, 1);
      end else begin
        want = pending_speeds.pop_front();
        check_field("wheel_one", want.one, out_wheel_one);
        check_field("wheel_two", want.two, out_wheel_two);
        check_field("wheel_three", want.three, out_wheel_three);
        speeds_checked++;
      end
    end
  end

  // Main sequence
  initial begin : stimulus
    cmd_row_t c;
    int n;

    // robot frame, values read straight off the projection
    directed_rows.push_back(cmd_row(FRAME_ROBOT, 0, 0, 0, 1'b1, 0, 0, 0));
    directed_rows.push_back(cmd_row(FRAME_ROBOT, -32768, 0, 0, 1'b1, -16384, -16384, 32768));
    directed_rows.push_back(cmd_row(FRAME_ROBOT, 32767, 0, 0, 1'b1, 16384, 16384, -32767));
    directed_rows.push_back(cmd_row(FRAME_ROBOT, 0, 32767, 0, 1'b1, 28377, -28377, 0));
    directed_rows.push_back(cmd_row(FRAME_ROBOT, 0, -32768, 0, 1'b1, -28378, 28378, 0));
    // heading must be ignored in robot frame
    directed_rows.push_back(cmd_row(FRAME_ROBOT, 32767, 0, 16'hFFFF, 1'b1, 16384, 16384,
                                    -32767));
    directed_rows.push_back(cmd_row(FRAME_ROBOT, -32768, -32768, 16'h8000));
    directed_rows.push_back(cmd_row(FRAME_ROBOT, 32767, 32767, 16'h4000));
    directed_rows.push_back(cmd_row(FRAME_ROBOT, 32767, -32768, 0));
    // world frame across quadrant edges
    directed_rows.push_back(cmd_row(FRAME_WORLD, 0, 0, 16'h1234));
    directed_rows.push_back(cmd_row(FRAME_WORLD, 32767, 0, 16'h0000));
    directed_rows.push_back(cmd_row(FRAME_WORLD, 32767, 0, 16'h0001));
    directed_rows.push_back(cmd_row(FRAME_WORLD, 0, 32767, 16'h3FFF));
    directed_rows.push_back(cmd_row(FRAME_WORLD, 32767, 0, 16'h4000));
    directed_rows.push_back(cmd_row(FRAME_WORLD, -32768, 0, 16'h4001));
    directed_rows.push_back(cmd_row(FRAME_WORLD, 0, -32768, 16'h7FFF));
    directed_rows.push_back(cmd_row(FRAME_WORLD, 32767, 32767, 16'h8000));
    directed_rows.push_back(cmd_row(FRAME_WORLD, -32768, 32767, 16'hBFFF));
    directed_rows.push_back(cmd_row(FRAME_WORLD, 32767, -32768, 16'hC000));
    directed_rows.push_back(cmd_row(FRAME_WORLD, -32768, -32768, 16'hFFFF));
    // largest vector at 45 degree headings
    directed_rows.push_back(cmd_row(FRAME_WORLD, -32768, -32768, 16'h2000));
    directed_rows.push_back(cmd_row(FRAME_WORLD, 32767, 32767, 16'hE000));
    directed_rows.push_back(cmd_row(FRAME_WORLD, -32768, 32767, 16'h6000));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) send_command(directed_rows[i]);
    drain_pending();

    for (n = 0; n < RANDOM_CMDS; n++) begin
      // back-to-back stretch on both sides
      no_idle = (n >= 100 && n < 180);
      if (n == 225) drain_pending();
      c.mode = ($urandom_range(0, 3) != 0) ? FRAME_WORLD : FRAME_ROBOT;
      c.vx = pick_velocity();
      c.vy = pick_velocity();
      c.hd = pick_heading();
      c.typed = 1'b0;
      c.speeds = '0;
      send_command(c);
    end
    no_idle = 1'b0;
    drain_pending();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d world-frame and %0d robot-frame commands, %0d results scored",
             world_cmds, robot_cmds, speeds_checked);
    $display("%0d mismatches over %0d cycles", error_count, cycle_count);
    if (error_count == 0 && pending_speeds.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- omni_three_wheel_kinematics_top.f -----
design/otwk_pkg.sv
design/omni_three_wheel_kinematics_top.sv
bench/tb_omni_three_wheel_kinematics_top.sv
